### rtl/core/bmc_pkg.sv
// Shared types, codes and helpers for the best master clock selection block.
`default_nettype none

package bmc_pkg;

    localparam int MAX_RECORDS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int IN_TDATA_W  = 208;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 168;

    localparam logic [7:0] CLASS_PASSIVE_LIMIT = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY2  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ONLY = 3'd6;

    // Port state codes carried with each item.
    localparam logic [2:0] PS_LISTENING = 3'd0;
    localparam logic [2:0] PS_MASTER    = 3'd1;

    typedef enum logic [2:0] {
        DEC_MASTER    = 3'd0,
        DEC_SLAVE     = 3'd1,
        DEC_PASSIVE   = 3'd2,
        DEC_LISTENING = 3'd3,
        DEC_FAULTY    = 3'd4
    } dec_t;

    typedef enum logic [1:0] {
        CMP_A_BETTER,
        CMP_B_BETTER,
        CMP_TIE
    } cmp_t;

    // One clock data set as it takes part in a comparison.
    typedef struct packed {
        logic [63:0] gm_id;
        logic [47:0] quality;
        logic [15:0] hops;
        logic [63:0] sender_id;
        logic [15:0] sender_port;
    } dset_t;

    typedef struct packed {
        dset_t      ds;
        logic       last;
        logic [2:0] port_state;
        logic       no_records;
    } rec_t;

    typedef struct packed {
        logic [7:0]  priority1;
        logic [7:0]  priority2;
        logic [7:0]  clock_class;
        logic [7:0]  accuracy;
        logic [15:0] variance;
        logic [63:0] identity;
        logic        slave_only;
    } cfg_t;

    typedef struct packed {
        dec_t        decision;
        logic [3:0]  best_index;
        logic [63:0] parent_id;
        logic [15:0] parent_port;
        logic [63:0] grandmaster;
        logic [16:0] steps;
    } res_t;

    // Priority1 is most significant, so a plain compare ranks the whole quality.
    function automatic logic [47:0] pack_quality(
        input logic [7:0]  p1,
        input logic [7:0]  cls,
        input logic [7:0]  acc,
        input logic [15:0] var_in,
        input logic [7:0]  p2
    );
        pack_quality = {p1, cls, acc, var_in, p2};
    endfunction

endpackage

`default_nettype wire

### rtl/core/best_master_clock_select.sv
// Top level of the best master clock selection block.
//
//  Channel  | Direction | Handshake              | Contents
//  ---------+-----------+------------------------+-----------------------------------
//  s_axis   | in        | tvalid / tready        | announce record, tlast ends round
//  m_axis   | out       | tvalid / tready        | decision and parent data set
//  cfg      | in        | cfg_wr_en, no wait     | local clock data set, slave_only
//
// One item per clock cycle is sustained while m_axis does not stall. An accepted
// item sits in the input register, is ranked against the stored best by a single
// pass of comparators, and its result, if any, lands in the output register.
// The stored best record and the parent are updated in the same cycle as the output register, so the
// next item sees them at once. A stall on m_axis holds an item in the input
// register only when it would produce a result. After reset, the configuration
// registers hold their defaults and the round and parent are cleared.
`default_nettype none

module best_master_clock_select
    import bmc_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // gm_identity, gm_priority1, gm_clock_class, gm_clock_accuracy,
    // gm_offset_variance, gm_priority2, hops_removed, sender_identity, sender_port
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // port_state, no_records
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   s_axis_tlast,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // decision, best_index, parent_id_out, parent_port_out, grandmaster_out, steps_out
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    rec_t in_reg;
    rec_t in_next;
    logic in_valid_reg;
    res_t out_reg;
    logic out_valid_reg;

    res_t res;
    logic res_valid;
    logic take;
    logic in_accept;

    assign in_next.ds.gm_id       = s_axis_tdata[63:0];
    assign in_next.ds.quality     = pack_quality(s_axis_tdata[71:64], s_axis_tdata[79:72],
                                                 s_axis_tdata[87:80], s_axis_tdata[103:88],
                                                 s_axis_tdata[111:104]);
    assign in_next.ds.hops        = s_axis_tdata[127:112];
    assign in_next.ds.sender_id   = s_axis_tdata[191:128];
    assign in_next.ds.sender_port = s_axis_tdata[207:192];
    assign in_next.last           = s_axis_tlast;
    assign in_next.port_state     = s_axis_tuser[2:0];
    assign in_next.no_records     = s_axis_tuser[3];

    // An item without a result never waits on the output side.
    assign take          = in_valid_reg && (!res_valid || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || take;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    bmc_select #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_select
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec       (in_reg),
        .take      (take),
        .res       (res),
        .res_valid (res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.priority1   <= 8'd128;
            cfg_reg.priority2   <= 8'd128;
            cfg_reg.clock_class <= 8'd248;
            cfg_reg.accuracy    <= 8'd254;
            cfg_reg.variance    <= 16'hFFFF;
            cfg_reg.identity    <= 64'd0;
            cfg_reg.slave_only  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PRIORITY1:  cfg_reg.priority1   <= cfg_data[7:0];
                CFG_PRIORITY2:  cfg_reg.priority2   <= cfg_data[7:0];
                CFG_CLASS:      cfg_reg.clock_class <= cfg_data[7:0];
                CFG_ACCURACY:   cfg_reg.accuracy    <= cfg_data[7:0];
                CFG_VARIANCE:   cfg_reg.variance    <= cfg_data[15:0];
                CFG_IDENTITY:   cfg_reg.identity    <= cfg_data;
                CFG_SLAVE_ONLY: cfg_reg.slave_only  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (take)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_reg <= in_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.steps, out_reg.grandmaster, out_reg.parent_port,
                            out_reg.parent_id, out_reg.best_index, out_reg.decision};

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input ready dropped without a stalled result");

    a_master_parent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.decision == DEC_MASTER |->
            out_reg.parent_id == out_reg.grandmaster && out_reg.parent_port == 16'd0 &&
            out_reg.steps == 17'd0)
        else $error("master result does not name the local clock as parent");

    a_slave_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.decision == DEC_SLAVE || out_reg.decision == DEC_PASSIVE)
            |-> out_reg.steps != 17'd0)
        else $error("slave or passive result with zero steps removed");

    a_idle_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.decision == DEC_LISTENING ||
                          out_reg.decision == DEC_FAULTY)
            |-> out_reg.grandmaster == 64'd0 && out_reg.steps == 17'd0)
        else $error("listening or faulty result carries a grandmaster");

endmodule

`default_nettype wire

### rtl/core/bmc_compare.sv
// Data set comparator: ranks data set a against data set b, including the topology rule.
`default_nettype none

module bmc_compare
    import bmc_pkg::*;
(
    input  dset_t       a,
    input  dset_t       b,
    input  logic [63:0] parent_id,
    output cmp_t        result
);

    logic [16:0] ha;
    logic [16:0] hb;
    logic        a_far;
    logic        b_far;

    assign ha    = {1'b0, a.hops};
    assign hb    = {1'b0, b.hops};
    assign a_far = ha > (hb + 17'd1);
    assign b_far = hb > (ha + 17'd1);

    always_comb
    begin
        if (a.gm_id != b.gm_id)
        begin
            if (a.quality != b.quality)
                result = (a.quality < b.quality) ? CMP_A_BETTER : CMP_B_BETTER;
            else
                result = (a.gm_id < b.gm_id) ? CMP_A_BETTER : CMP_B_BETTER;
        end
        else if (a_far)
            result = CMP_B_BETTER;
        else if (b_far)
            result = CMP_A_BETTER;
        else if (ha > hb)
            // One step further away only ties when it comes through our parent.
            result = (a.sender_id == parent_id) ? CMP_TIE : CMP_B_BETTER;
        else if (hb > ha)
            result = (b.sender_id == parent_id) ? CMP_TIE : CMP_A_BETTER;
        else if (a.sender_id == b.sender_id)
            result = CMP_TIE;
        else
            result = (a.sender_id < b.sender_id) ? CMP_A_BETTER : CMP_B_BETTER;
    end

endmodule

`default_nettype wire

### rtl/core/bmc_select.sv
// Running best record, parent data set and end-of-round decision.
`default_nettype none

module bmc_select
    import bmc_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  rec_t rec,
    input  logic take,
    output res_t res,
    output logic res_valid
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    dset_t            best_reg;
    dset_t            best_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] slot_reg;
    logic [CNT_W-1:0] slot_next;
    logic [63:0]      parent_id_reg;
    logic [63:0]      parent_id_next;
    logic [15:0]      parent_port_reg;
    logic [15:0]      parent_port_next;

    dset_t            local_ds;
    cmp_t             cmp_rec_best;
    cmp_t             cmp_loc_rec;
    cmp_t             cmp_loc_best;
    cmp_t             cmp_final;
    logic             in_range;
    logic             replace;
    dec_t             dec;
    logic [CNT_W+3:0] slot_ext;

    assign local_ds.gm_id       = cfg.identity;
    assign local_ds.quality     = pack_quality(cfg.priority1, cfg.clock_class, cfg.accuracy,
                                               cfg.variance, cfg.priority2);
    assign local_ds.hops        = 16'd0;
    assign local_ds.sender_id   = cfg.identity;
    assign local_ds.sender_port = 16'd0;

    // The local set is ranked against both candidates at once, and whether the
    // record replaces the best picks which answer applies.
    bmc_compare u_cmp_rec_best
    (
        .a         (rec.ds),
        .b         (best_reg),
        .parent_id (parent_id_reg),
        .result    (cmp_rec_best)
    );

    bmc_compare u_cmp_loc_rec
    (
        .a         (local_ds),
        .b         (rec.ds),
        .parent_id (parent_id_reg),
        .result    (cmp_loc_rec)
    );

    bmc_compare u_cmp_loc_best
    (
        .a         (local_ds),
        .b         (best_reg),
        .parent_id (parent_id_reg),
        .result    (cmp_loc_best)
    );

    assign in_range  = count_reg < CNT_MAX;
    assign replace   = !rec.no_records && in_range &&
                       ((count_reg == '0) || (cmp_rec_best == CMP_A_BETTER));
    assign best_next = replace ? rec.ds : best_reg;
    assign slot_next = replace ? count_reg : slot_reg;
    assign cmp_final = replace ? cmp_loc_rec : cmp_loc_best;
    assign res_valid = rec.no_records || rec.last;
    assign slot_ext  = {4'd0, slot_next};

    always_comb
    begin
        if (rec.no_records)
            count_next = '0;
        else if (rec.last)
            count_next = '0;
        else if (in_range)
            count_next = count_reg + CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_comb
    begin
        if (rec.no_records)
        begin
            if (rec.port_state == PS_MASTER)
                dec = DEC_MASTER;
            else if (rec.port_state == PS_LISTENING)
                dec = DEC_LISTENING;
            else
                dec = DEC_FAULTY;
        end
        else if (cfg.slave_only)
            dec = DEC_SLAVE;
        else
        begin
            case (cmp_final)
                CMP_A_BETTER: dec = DEC_MASTER;
                CMP_B_BETTER: dec = (cfg.clock_class < CLASS_PASSIVE_LIMIT) ?
                                    DEC_PASSIVE : DEC_SLAVE;
                CMP_TIE:      dec = DEC_FAULTY;
                default:      dec = DEC_FAULTY;
            endcase
        end
    end

    always_comb
    begin
        parent_id_next   = parent_id_reg;
        parent_port_next = parent_port_reg;
        res.grandmaster  = 64'd0;
        res.steps        = 17'd0;
        case (dec)
            DEC_MASTER:
            begin
                parent_id_next   = cfg.identity;
                parent_port_next = 16'd0;
                res.grandmaster  = cfg.identity;
            end
            DEC_SLAVE, DEC_PASSIVE:
            begin
                parent_id_next   = best_next.sender_id;
                parent_port_next = best_next.sender_port;
                res.grandmaster  = best_next.gm_id;
                res.steps        = {1'b0, best_next.hops} + 17'd1;
            end
            default:
            begin
                parent_id_next   = parent_id_reg;
                parent_port_next = parent_port_reg;
            end
        endcase
        res.decision    = dec;
        res.best_index  = rec.no_records ? 4'd0 : slot_ext[3:0];
        res.parent_id   = parent_id_next;
        res.parent_port = parent_port_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg        <= '0;
            count_reg       <= '0;
            slot_reg        <= '0;
            parent_id_reg   <= 64'd0;
            parent_port_reg <= 16'd0;
        end
        else if (take)
        begin
            best_reg  <= best_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            if (res_valid)
            begin
                parent_id_reg   <= parent_id_next;
                parent_port_reg <= parent_port_next;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("record count beyond the round limit");

    a_round_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid |=> count_reg == '0)
        else $error("record count not cleared at the end of a round");

    a_slot_seen: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> slot_reg < count_reg)
        else $error("best slot points past the records taken");

endmodule

`default_nettype wire
